// ----- rtl/arbf_pkg.sv -----
// ----------------------------------------------------------------------------
// arbf_pkg - shared types and constants for the audio ring bank block FIFO
// Field widths, default geometry and the sequencer state encoding.
// ----------------------------------------------------------------------------
package arbf_pkg;

    localparam int RING_FRAMES_DEF = 4096;
    localparam int RING_COUNT_DEF  = 32;

    localparam int RING_IDX_W = 5;
    localparam int FRAMES_W   = 13;
    localparam int SAMPLE_W   = 32;
    localparam int COUNT_W    = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PTR   = 4'b0010,
        S_EXEC  = 4'b0100,
        S_RDATA = 4'b1000
    } t_state;

endpackage

// ----- rtl/arbf_ram.sv -----
// ----------------------------------------------------------------------------
// arbf_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module arbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/audio_ring_bank_block_fifo.sv -----
// ----------------------------------------------------------------------------
// audio_ring_bank_block_fifo - bank of per-channel sample rings
// Block-granular admission: write blocks must fit whole, read blocks must be
// fully stored, refused blocks are dropped or return silence and counted.
// ----------------------------------------------------------------------------
// Timing: every request passes S_EXEC before its result strobe; the first
// item of a block also passes S_PTR (pointer memory read), and an admitted
// read also passes S_RDATA (sample memory read). A new request is taken only
// in S_IDLE, so busy stays high until the result is registered.
// The receiver cannot stall.
// Reset (synchronous, active low) clears pointers via per-ring valid bits,
// counters and block state at once; the sample memory is not cleared.
module audio_ring_bank_block_fifo #(
    parameter int RING_FRAMES = arbf_pkg::RING_FRAMES_DEF,
    parameter int RING_COUNT  = arbf_pkg::RING_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_action,
    input  logic [arbf_pkg::RING_IDX_W-1:0] i_ring_index,
    input  logic                            i_block_start,
    input  logic [arbf_pkg::FRAMES_W-1:0]   i_block_frames,
    input  logic [arbf_pkg::SAMPLE_W-1:0]   i_sample_in,
    output logic                            o_valid,
    output logic [arbf_pkg::SAMPLE_W-1:0]   o_sample_out,
    output logic                            o_admitted,
    output logic                            o_block_end,
    output logic [arbf_pkg::COUNT_W-1:0]    o_overrun_total,
    output logic [arbf_pkg::COUNT_W-1:0]    o_underrun_total
);

    localparam int SPAN = 2 * RING_FRAMES;
    localparam int PW   = $clog2(SPAN);
    localparam int SW   = $clog2(RING_FRAMES);
    localparam int RIW  = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
    localparam int AW   = $clog2(RING_COUNT * RING_FRAMES);
    localparam int FW   = arbf_pkg::FRAMES_W;
    localparam int CW   = ((PW > FW) ? PW : FW) + 1;
    localparam int DW   = arbf_pkg::SAMPLE_W;
    localparam int NW   = arbf_pkg::COUNT_W;

    arbf_pkg::t_state r_state;

    // latched request
    logic                            r_req_action;
    logic [arbf_pkg::RING_IDX_W-1:0] r_req_ring;
    logic [FW-1:0]                   r_req_frames;
    logic [DW-1:0]                   r_req_sample;

    // pointer memory bookkeeping
    logic [RING_COUNT-1:0] r_ptr_vld;
    logic                  r_ptr_vld_q;

    // active block
    logic [FW-1:0]  r_blk_len;
    logic [FW-1:0]  r_blk_off;
    logic           r_blk_adm;
    logic           r_blk_read;
    logic [RIW-1:0] r_blk_ring;
    logic [SW-1:0]  r_blk_slot;
    logic [PW-1:0]  r_blk_wp;
    logic [PW-1:0]  r_blk_rp;

    logic [NW-1:0] r_overrun;
    logic [NW-1:0] r_underrun;

    logic          r_valid;
    logic [DW-1:0] r_sample_out;
    logic          r_admitted;
    logic          r_block_end;

    logic            accept;
    logic            in_ring_ok;
    logic [RIW-1:0]  ptr_raddr;
    logic [2*PW-1:0] ptr_rdata;
    logic            ptr_we;
    logic [2*PW-1:0] ptr_wdata;

    logic [PW-1:0] rd_wp;
    logic [PW-1:0] rd_rp;
    logic [PW:0]   fill_raw;
    logic [PW-1:0] fill;
    logic [FW-1:0] req_len;
    logic          req_ring_ok;
    logic          fits;
    logic          stored;
    logic          req_adm;
    logic [PW-1:0] base_ptr;
    logic [SW-1:0] slot0;

    logic          blk_active;
    logic [FW-1:0] off_inc;
    logic          blk_last;
    logic [SW-1:0] slot_inc;
    logic [PW-1:0] cur_ptr;
    logic [PW:0]   adv_sum;
    logic [PW-1:0] adv_ptr;

    logic          sram_we;
    logic [AW-1:0] sram_addr;
    logic [DW-1:0] sram_rdata;

    assign accept     = i_start && (r_state == arbf_pkg::S_IDLE);
    assign in_ring_ok = 32'(i_ring_index) < 32'(RING_COUNT);
    assign ptr_raddr  = RIW'(i_ring_index);

    // admission decision, pointers arrive from memory in S_PTR
    assign rd_wp    = r_ptr_vld_q ? ptr_rdata[2*PW-1:PW] : '0;
    assign rd_rp    = r_ptr_vld_q ? ptr_rdata[PW-1:0]    : '0;
    assign fill_raw = {1'b0, rd_wp} + (PW+1)'(SPAN) - {1'b0, rd_rp};
    assign fill     = (fill_raw >= (PW+1)'(SPAN)) ? PW'(fill_raw - (PW+1)'(SPAN))
                                                  : PW'(fill_raw);
    assign req_len     = (r_req_frames == '0) ? FW'(1) : r_req_frames;
    assign req_ring_ok = 32'(r_req_ring) < 32'(RING_COUNT);
    assign fits        = (CW'(fill) + CW'(req_len)) <= CW'(RING_FRAMES);
    assign stored      = CW'(fill) >= CW'(req_len);
    assign req_adm     = req_ring_ok && (r_req_action ? stored : fits);
    assign base_ptr    = r_req_action ? rd_rp : rd_wp;
    assign slot0       = (base_ptr >= PW'(RING_FRAMES)) ? SW'(base_ptr - PW'(RING_FRAMES))
                                                        : SW'(base_ptr);

    // per-item step of the active block
    assign blk_active = (r_blk_len != '0);
    assign off_inc    = r_blk_off + FW'(1);
    assign blk_last   = (off_inc >= r_blk_len);
    assign slot_inc   = (r_blk_slot == SW'(RING_FRAMES - 1)) ? '0 : r_blk_slot + SW'(1);
    assign cur_ptr    = r_blk_read ? r_blk_rp : r_blk_wp;
    // admitted length never exceeds RING_FRAMES, so the truncation is exact
    assign adv_sum    = {1'b0, cur_ptr} + (PW+1)'(r_blk_len);
    assign adv_ptr    = (adv_sum >= (PW+1)'(SPAN)) ? PW'(adv_sum - (PW+1)'(SPAN))
                                                   : PW'(adv_sum);
    assign ptr_wdata  = r_blk_read ? {r_blk_wp, adv_ptr} : {adv_ptr, r_blk_rp};
    assign ptr_we     = (r_state == arbf_pkg::S_EXEC) && blk_active && blk_last && r_blk_adm;

    assign sram_we   = (r_state == arbf_pkg::S_EXEC) && blk_active && r_blk_adm && !r_blk_read;
    assign sram_addr = AW'(32'(r_blk_ring) * 32'(RING_FRAMES) + 32'(r_blk_slot));

    arbf_ram #(
        .WIDTH (2 * PW),
        .DEPTH (RING_COUNT)
    ) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (ptr_we),
        .i_waddr (r_blk_ring),
        .i_wdata (ptr_wdata),
        .i_raddr (ptr_raddr),
        .o_rdata (ptr_rdata)
    );

    arbf_ram #(
        .WIDTH (DW),
        .DEPTH (RING_COUNT * RING_FRAMES)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (sram_we),
        .i_waddr (sram_addr),
        .i_wdata (r_req_sample),
        .i_raddr (sram_addr),
        .o_rdata (sram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= arbf_pkg::S_IDLE;
            r_valid    <= 1'b0;
            r_ptr_vld  <= '0;
            r_blk_len  <= '0;
            r_blk_off  <= '0;
            r_blk_adm  <= 1'b0;
            r_overrun  <= '0;
            r_underrun <= '0;
        end else begin
            r_valid <= 1'b0;
            if (ptr_we) begin
                r_ptr_vld[r_blk_ring] <= 1'b1;
            end
            unique case (r_state)
                arbf_pkg::S_IDLE: begin
                    if (accept) begin
                        r_state <= i_block_start ? arbf_pkg::S_PTR : arbf_pkg::S_EXEC;
                    end
                end
                arbf_pkg::S_PTR: begin
                    // a new block abandons any active one
                    r_blk_len <= req_len;
                    r_blk_off <= '0;
                    r_blk_adm <= req_adm;
                    if (!req_adm) begin
                        if (r_req_action) begin
                            if (r_underrun != arbf_pkg::COUNT_MAX) begin
                                r_underrun <= r_underrun + NW'(1);
                            end
                        end else begin
                            if (r_overrun != arbf_pkg::COUNT_MAX) begin
                                r_overrun <= r_overrun + NW'(1);
                            end
                        end
                    end
                    r_state <= arbf_pkg::S_EXEC;
                end
                arbf_pkg::S_EXEC: begin
                    if (blk_active) begin
                        if (blk_last) begin
                            r_blk_len <= '0;
                            r_blk_off <= '0;
                            r_blk_adm <= 1'b0;
                        end else begin
                            r_blk_off <= off_inc;
                        end
                    end
                    if (blk_active && r_blk_adm && r_blk_read) begin
                        r_state <= arbf_pkg::S_RDATA;
                    end else begin
                        r_valid <= 1'b1;
                        r_state <= arbf_pkg::S_IDLE;
                    end
                end
                arbf_pkg::S_RDATA: begin
                    r_valid <= 1'b1;
                    r_state <= arbf_pkg::S_IDLE;
                end
                default: begin
                    r_state <= arbf_pkg::S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_action <= i_action;
            r_req_ring   <= i_ring_index;
            r_req_frames <= i_block_frames;
            r_req_sample <= i_sample_in;
            r_ptr_vld_q  <= in_ring_ok ? r_ptr_vld[ptr_raddr] : 1'b0;
        end
        if (r_state == arbf_pkg::S_PTR) begin
            r_blk_read <= r_req_action;
            r_blk_ring <= RIW'(r_req_ring);
            r_blk_slot <= slot0;
            r_blk_wp   <= rd_wp;
            r_blk_rp   <= rd_rp;
        end
        if (r_state == arbf_pkg::S_EXEC) begin
            r_admitted   <= blk_active && r_blk_adm;
            r_block_end  <= blk_active && blk_last;
            r_sample_out <= '0;
            if (blk_active && !blk_last) begin
                r_blk_slot <= slot_inc;
            end
        end
        if (r_state == arbf_pkg::S_RDATA) begin
            r_sample_out <= sram_rdata;
        end
    end

    assign o_busy           = (r_state != arbf_pkg::S_IDLE);
    assign o_valid          = r_valid;
    assign o_sample_out     = r_sample_out;
    assign o_admitted       = r_admitted;
    assign o_block_end      = r_block_end;
    assign o_overrun_total  = r_overrun;
    assign o_underrun_total = r_underrun;

    // result strobes are never back to back
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe on consecutive cycles");

    // refused or ignored items carry silence
    a_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_admitted) |-> (o_sample_out == '0))
        else $error("nonzero sample on a refused item");

    // counters never move backward
    a_overrun_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (o_overrun_total >= $past(o_overrun_total)))
        else $error("overrun count decreased");

    a_underrun_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (o_underrun_total >= $past(o_underrun_total)))
        else $error("underrun count decreased");

    // pointer write-back only at the last item of an admitted block
    a_ptr_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ptr_we |=> (o_valid || r_state == arbf_pkg::S_RDATA))
        else $error("pointer write-back outside a block end");

endmodule

// ----- dv/arbf_ring_checker.sv -----
// ----------------------------------------------------------------------------
// arbf_ring_checker - result predictor and checker for the ring bank FIFO
// Watches accepted requests and result strobes, keeps its own copy of the
// ring pointers, sample store, block state and refusal counters, and compares
// every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module arbf_ring_checker
    import arbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic                  i_action,
    input  logic [RING_IDX_W-1:0] i_ring_index,
    input  logic                  i_block_start,
    input  logic [FRAMES_W-1:0]   i_block_frames,
    input  logic [SAMPLE_W-1:0]   i_sample_in,
    input  logic                  i_valid,
    input  logic [SAMPLE_W-1:0]   i_sample_out,
    input  logic                  i_admitted,
    input  logic                  i_block_end,
    input  logic [COUNT_W-1:0]    i_overrun_total,
    input  logic [COUNT_W-1:0]    i_underrun_total,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int FRAMES   = RING_FRAMES_DEF;
    localparam int RINGS    = RING_COUNT_DEF;
    localparam int PTR_SPAN = 2 * FRAMES;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                admitted;
        logic                block_end;
        logic [COUNT_W-1:0]  overruns;
        logic [COUNT_W-1:0]  underruns;
    } t_frame_result;

    logic [SAMPLE_W-1:0] ring_mem [RINGS*FRAMES];
    int                  wr_ptr [RINGS];
    int                  rd_ptr [RINGS];
    logic                blk_ok;
    logic                blk_read;
    int                  blk_ring;
    int                  blk_len;
    int                  blk_offset;
    logic [COUNT_W-1:0]  overruns;
    logic [COUNT_W-1:0]  underruns;
    t_frame_result       expected_q [$];

    function automatic t_frame_result predict_frame(
        input logic                  act,
        input logic [RING_IDX_W-1:0] ring,
        input logic                  bstart,
        input logic [FRAMES_W-1:0]   frames,
        input logic [SAMPLE_W-1:0]   smp
    );
        t_frame_result r;
        int            fill;
        int            base;
        int            idx;
        r = '0;
        if (bstart) begin
            // a new block abandons whatever block is still open
            blk_read   = act;
            blk_ring   = int'(ring);
            blk_len    = (frames == '0) ? 1 : int'(frames);
            blk_offset = 0;
            if (blk_ring >= RINGS) begin
                blk_ok = 1'b0;
            end else begin
                fill = (wr_ptr[blk_ring] + PTR_SPAN - rd_ptr[blk_ring]) % PTR_SPAN;
                if (blk_read) begin
                    blk_ok = (fill >= blk_len);
                end else begin
                    blk_ok = (fill + blk_len <= FRAMES);
                end
            end
            if (!blk_ok) begin
                if (blk_read) begin
                    if (underruns != COUNT_MAX) underruns++;
                end else begin
                    if (overruns != COUNT_MAX) overruns++;
                end
            end
        end
        if (blk_len != 0) begin
            r.admitted = blk_ok;
            if (blk_ok) begin
                base = blk_read ? rd_ptr[blk_ring] : wr_ptr[blk_ring];
                idx  = blk_ring * FRAMES + (base + blk_offset) % FRAMES;
                if (blk_read) begin
                    r.sample = ring_mem[idx];
                end else begin
                    ring_mem[idx] = smp;
                end
            end
            blk_offset++;
            if (blk_offset >= blk_len) begin
                r.block_end = 1'b1;
                if (blk_ok) begin
                    if (blk_read) begin
                        rd_ptr[blk_ring] = (rd_ptr[blk_ring] + blk_len) % PTR_SPAN;
                    end else begin
                        wr_ptr[blk_ring] = (wr_ptr[blk_ring] + blk_len) % PTR_SPAN;
                    end
                end
                blk_len    = 0;
                blk_offset = 0;
                blk_ok     = 1'b0;
            end
        end
        r.overruns  = overruns;
        r.underruns = underruns;
        return r;
    endfunction

    function automatic int field_mismatch(
        input string       name,
        input logic [63:0] exp_val,
        input logic [63:0] act_val
    );
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_frame_result exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < RINGS; i++) begin
                wr_ptr[i] = 0;
                rd_ptr[i] = 0;
            end
            blk_ok     = 1'b0;
            blk_read   = 1'b0;
            blk_ring   = 0;
            blk_len    = 0;
            blk_offset = 0;
            overruns   = '0;
            underruns  = '0;
            expected_q.delete();
        end else begin
            // compare before pushing: a strobe never belongs to the request
            // accepted at the same edge
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request pending: sample_out %0h", i_sample_out);
                    o_fail_count++;
                end else begin
                    exp_r = expected_q.pop_front();
                    o_fail_count += field_mismatch("sample_out", 64'(exp_r.sample),
                                                   64'(i_sample_out));
                    o_fail_count += field_mismatch("admitted", 64'(exp_r.admitted),
                                                   64'(i_admitted));
                    o_fail_count += field_mismatch("block_end", 64'(exp_r.block_end),
                                                   64'(i_block_end));
                    o_fail_count += field_mismatch("overrun_total", 64'(exp_r.overruns),
                                                   64'(i_overrun_total));
                    o_fail_count += field_mismatch("underrun_total", 64'(exp_r.underruns),
                                                   64'(i_underrun_total));
                end
            end
            if (i_start && !i_busy) begin
                expected_q.push_back(predict_frame(i_action, i_ring_index, i_block_start,
                                                   i_block_frames, i_sample_in));
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- dv/tb_audio_ring_bank_block_fifo.sv -----
// ----------------------------------------------------------------------------
// tb_audio_ring_bank_block_fifo - testbench for the audio ring bank FIFO
// Drives directed blocks (empty rings, zero and oversize frame counts,
// restarts, stray items) and then random block traffic in bursts with
// random gaps; a side checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_audio_ring_bank_block_fifo;
    import arbf_pkg::*;

    localparam int FRAMES       = RING_FRAMES_DEF;
    localparam int RANDOM_ITEMS = 1010;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic                  action       = 1'b0;
    logic [RING_IDX_W-1:0] ring_index   = '0;
    logic                  block_start  = 1'b0;
    logic [FRAMES_W-1:0]   block_frames = '0;
    logic [SAMPLE_W-1:0]   sample_in    = '0;
    logic                  valid;
    logic [SAMPLE_W-1:0]   sample_out;
    logic                  admitted;
    logic                  block_end;
    logic [COUNT_W-1:0]    overrun_total;
    logic [COUNT_W-1:0]    underrun_total;
    int                    fail_count;
    int                    pending;
    int                    burst_left   = 0;

    always #4 clk = ~clk;

    audio_ring_bank_block_fifo u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_action         (action),
        .i_ring_index     (ring_index),
        .i_block_start    (block_start),
        .i_block_frames   (block_frames),
        .i_sample_in      (sample_in),
        .o_valid          (valid),
        .o_sample_out     (sample_out),
        .o_admitted       (admitted),
        .o_block_end      (block_end),
        .o_overrun_total  (overrun_total),
        .o_underrun_total (underrun_total)
    );

    arbf_ring_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_action         (action),
        .i_ring_index     (ring_index),
        .i_block_start    (block_start),
        .i_block_frames   (block_frames),
        .i_sample_in      (sample_in),
        .i_valid          (valid),
        .i_sample_out     (sample_out),
        .i_admitted       (admitted),
        .i_block_end      (block_end),
        .i_overrun_total  (overrun_total),
        .i_underrun_total (underrun_total),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Present one request and hold it until accepted; idle between bursts.
    task automatic drive_request(
        input logic                  act,
        input logic [RING_IDX_W-1:0] ring,
        input logic                  bstart,
        input logic [FRAMES_W-1:0]   frames,
        input logic [SAMPLE_W-1:0]   smp
    );
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(20, 10) : $urandom_range(6, 1);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(300, 100)
                                                  : $urandom_range(24, 1);
        end
        burst_left--;
        @(negedge clk);
        start        <= 1'b1;
        action       <= act;
        ring_index   <= ring;
        block_start  <= bstart;
        block_frames <= frames;
        sample_in    <= smp;
        do @(posedge clk); while (busy);
    endtask

    // Send the first count items of a block; later items carry noise in the
    // fields that only the first item defines.
    task automatic send_block(
        input logic                  act,
        input logic [RING_IDX_W-1:0] ring,
        input logic [FRAMES_W-1:0]   frames,
        input int                    count
    );
        drive_request(act, ring, 1'b1, frames, $urandom());
        for (int i = 1; i < count; i++) begin
            drive_request(1'($urandom_range(1)), RING_IDX_W'($urandom_range(31)), 1'b0,
                          FRAMES_W'($urandom_range(8191)), $urandom());
        end
    endtask

    initial begin
        int                  random_items;
        int                  pick;
        int                  len;
        logic                act;
        logic [RING_IDX_W-1:0] ring;
        logic [FRAMES_W-1:0] frames;

        random_items = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // stray item with no block open
        drive_request(1'b1, 5'd31, 1'b0, 13'd8191, 32'hFFFF_FFFF);
        // read from an empty ring
        send_block(1'b1, 5'd5, 13'd2, 2);
        // zero frame count counts as one, then a three-frame write
        drive_request(1'b0, 5'd31, 1'b1, 13'd0, 32'hFFFF_FFFF);
        drive_request(1'b0, 5'd31, 1'b1, 13'd3, 32'h0000_0000);
        drive_request(1'b1, 5'd0, 1'b0, 13'd0, 32'hA5A5_A5A5);
        drive_request(1'b0, 5'd0, 1'b0, 13'd8191, 32'h5A5A_5A5A);
        // read exactly what is stored, then one more
        send_block(1'b1, 5'd31, 13'd4, 4);
        send_block(1'b1, 5'd31, 13'd1, 1);
        // abandoned write leaves nothing stored
        send_block(1'b0, 5'd2, 13'd5, 2);
        send_block(1'b1, 5'd2, 13'd1, 1);
        // oversize read runs its full length
        send_block(1'b1, 5'd3, 13'd9, 9);
        // oversize requests cut short by restarts
        send_block(1'b0, 5'd3, 13'd8191, 3);
        send_block(1'b1, 5'd2, 13'd4096, 2);
        send_block(1'b0, 5'd2, 13'd4097, 1);
        send_block(1'b0, 5'd2, 13'd1, 1);
        send_block(1'b1, 5'd2, 13'd2, 2);
        send_block(1'b1, 5'd2, 13'd1, 1);
        // abandoned read leaves the data in place
        send_block(1'b0, 5'd4, 13'd3, 3);
        send_block(1'b1, 5'd4, 13'd3, 2);
        send_block(1'b1, 5'd4, 13'd3, 3);

        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                drive_request(1'($urandom_range(1)), RING_IDX_W'($urandom_range(31)), 1'b0,
                              FRAMES_W'($urandom_range(8191)), $urandom());
                random_items++;
            end else begin
                act  = 1'($urandom_range(1));
                ring = ($urandom_range(9) < 7) ? RING_IDX_W'($urandom_range(3))
                                               : RING_IDX_W'($urandom_range(31));
                pick = $urandom_range(19);
                if (pick == 0) frames = '0;
                else if (pick < 3) frames = FRAMES_W'($urandom_range(64, 9));
                else if (pick == 3) frames = FRAMES_W'($urandom_range(8191, 4097));
                else frames = FRAMES_W'($urandom_range(8, 1));
                len = (frames == '0) ? 1 : int'(frames);
                // cut oversize blocks short always, others now and then
                if (int'(frames) > FRAMES) begin
                    len = $urandom_range(4, 1);
                end else if (len > 1 && $urandom_range(9) == 0) begin
                    len = $urandom_range(len - 1, 1);
                end
                send_block(act, ring, frames, len);
                random_items += len;
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
